/* rtl/core/graph_m_coloring_search_assert.svh */
// Assertion macros for the graph coloring search block.
// Used by rtl/core modules through `include; no other dependencies.
`ifndef GRAPH_M_COLORING_SEARCH_ASSERT_SVH
`define GRAPH_M_COLORING_SEARCH_ASSERT_SVH
`ifndef ASSERT_OFF
`define GMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define GMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define GMC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GMC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/gmc_pkg.sv */
// Package for the graph coloring search block: widths, action codes, states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gmc_pkg;
	localparam int MAX_VERTICES_DEF = 16;
	localparam int MAX_COLORS_DEF = 16;
	localparam int CFG_W = 5;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_EDGE  = 2'd1,
		ACT_START = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic REG_COLORS = 1'b0;
	localparam logic REG_VERTS  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_EDGE_RD,
		ST_EDGE_WA,
		ST_EDGE_WB,
		ST_TRY,
		ST_RESUME,
		ST_SCAN,
		ST_STEP,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

/* rtl/core/gmc_adj_mem.sv */
// Adjacency memory: one row per vertex, synchronous write and read.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module gmc_adj_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [DEPTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [DEPTH-1:0] rdata
);
	logic [DEPTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/core/graph_m_coloring_search.sv */
// Top level of the graph m-coloring search block: control, color memory.
// Depends on gmc_pkg, gmc_adj_mem and the assertion header.
//
// Usage: items enter on s_axis (tdata = action, vertex_a, vertex_b from the
// lowest bit). Action 0 clears the graph, 1 adds an undirected edge, 2 runs
// the search and returns one item on m_axis with colorable in tdata[0];
// action 3 does nothing. Registers 0 (num_colors) and 1 (num_vertices) are
// written through cfg_we/cfg_addr/cfg_wdata; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// After an add-edge item is accepted the block reads row a, updates row a,
// then updates row b; a clear writes every row, one row a cycle. A search
// makes, for each candidate color, a decision step, a scan of the colors
// already placed and an update step, and on each step back a decision and a
// resume step, so its length follows the backtracking tree and can be
// exponential. The result is presented right after the final decision cycle.
// Adjacency rows live in one memory; vertex colors live in a second memory
// whose single read port is swept once per candidate color.
// The block handles one item at a time; s_axis_tready is low while busy.
// A result waits in an output register while the receiver stalls, and the
// next item is taken only after it leaves. Reset starts a clear pass over
// every row before any item is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "graph_m_coloring_search_assert.svh"
module graph_m_coloring_search #(
	parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_COLORS = gmc_pkg::MAX_COLORS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // action[1:0], vertex_a[5:2], vertex_b[9:6]
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // colorable[0]
	input  wire logic       cfg_we,
	input  wire logic       cfg_addr,
	input  wire logic [gmc_pkg::CFG_W-1:0] cfg_wdata
);
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int CW = $clog2(MAX_COLORS + 1);

	gmc_pkg::state_t state_q, state_d;
	logic [gmc_pkg::CFG_W-1:0] ncol_q, nvert_q;
	logic [NW-1:0] n_eff;
	logic [CW-1:0] m_eff;
	logic [AW-1:0] cnt_q;     // clear row index
	logic [NW-1:0] v_q;       // search depth
	logic [CW:0] c_q;         // candidate color, one spare bit to reach m+1
	logic [NW-1:0] scan_q;    // next placed color to read
	logic pend_s1;            // a color read is in flight
	logic [AW-1:0] pend_idx_s1;
	logic [3:0] a_q, b_q;
	logic conflict_q, res_q, out_v_q;

	logic adj_we;
	logic [AW-1:0] adj_waddr, adj_raddr;
	logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;

	logic [CW-1:0] col_mem [MAX_VERTICES];
	logic col_we;
	logic [AW-1:0] col_waddr, col_raddr;
	logic [CW-1:0] col_wdata, col_rdata;

	assign n_eff = (int'(nvert_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(nvert_q);
	assign m_eff = (int'(ncol_q) > MAX_COLORS) ? CW'(MAX_COLORS) : CW'(ncol_q);

	gmc_adj_mem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);

	always_ff @(posedge clk) begin
		if (col_we) col_mem[col_waddr] <= col_wdata;
		col_rdata <= col_mem[col_raddr];
	end

	// Edge endpoints; an edge is stored only when both lie inside the graph.
	logic edge_hit;
	logic [AW-1:0] a_addr, b_addr;
	assign a_addr = AW'(a_q);
	assign b_addr = AW'(b_q);
	assign edge_hit = (int'(a_q) < int'(n_eff)) && (int'(b_q) < int'(n_eff));

	logic clearing, clear_last;
	assign clearing = (state_q == gmc_pkg::ST_CLEAR);
	assign clear_last = (cnt_q == AW'(MAX_VERTICES - 1));

	// The adjacency read port stays on row v during a search, so the row is
	// valid for every scan cycle. Only vertices below v hold a color.
	logic scan_more, cand_over, color_hit;
	logic [CW:0] c_inc;
	assign scan_more = (scan_q < v_q);
	assign cand_over = (c_q > {1'b0, m_eff});
	assign c_inc = c_q + (CW+1)'(1);
	assign color_hit = pend_s1 && adj_rdata[pend_idx_s1] && ({1'b0, col_rdata} == c_q);

	assign s_axis_tready = (state_q == gmc_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gmc_pkg::ST_IDLE:
				if (s_axis_tvalid && s_axis_tready) begin
					unique case (gmc_pkg::action_t'(s_axis_tdata[1:0]))
						gmc_pkg::ACT_CLEAR: state_d = gmc_pkg::ST_CLEAR;
						gmc_pkg::ACT_EDGE:  state_d = gmc_pkg::ST_EDGE_RD;
						gmc_pkg::ACT_START: state_d = gmc_pkg::ST_TRY;
						gmc_pkg::ACT_NONE:  state_d = gmc_pkg::ST_IDLE;
					endcase
				end
			gmc_pkg::ST_CLEAR:
				if (clear_last) state_d = gmc_pkg::ST_IDLE;
			gmc_pkg::ST_EDGE_RD: state_d = gmc_pkg::ST_EDGE_WA;
			gmc_pkg::ST_EDGE_WA: state_d = gmc_pkg::ST_EDGE_WB;
			gmc_pkg::ST_EDGE_WB: state_d = gmc_pkg::ST_IDLE;
			gmc_pkg::ST_TRY:
				if (v_q >= n_eff || (cand_over && v_q == '0)) state_d = gmc_pkg::ST_DONE;
				else if (cand_over) state_d = gmc_pkg::ST_RESUME;
				else state_d = gmc_pkg::ST_SCAN;
			gmc_pkg::ST_RESUME: state_d = gmc_pkg::ST_TRY;
			gmc_pkg::ST_SCAN:
				if (!scan_more) state_d = gmc_pkg::ST_STEP;
			gmc_pkg::ST_STEP: state_d = gmc_pkg::ST_TRY;
			gmc_pkg::ST_DONE:
				if (m_axis_tready) state_d = gmc_pkg::ST_IDLE;
			default: state_d = gmc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		adj_we = clearing;
		adj_waddr = cnt_q;
		adj_wdata = '0;
		adj_raddr = AW'(v_q);
		col_we = 1'b0;
		col_waddr = AW'(v_q);
		col_wdata = '0;
		col_raddr = AW'(scan_q);
		unique case (state_q)
			gmc_pkg::ST_EDGE_RD: adj_raddr = a_addr;
			gmc_pkg::ST_EDGE_WA: begin
				// Row b is read while row a is written; for a self loop the
				// old row comes back and gets the same bit.
				adj_raddr = b_addr;
				adj_we = edge_hit;
				adj_waddr = a_addr;
				adj_wdata = adj_rdata | (MAX_VERTICES'(1) << b_addr);
			end
			gmc_pkg::ST_EDGE_WB: begin
				adj_we = edge_hit;
				adj_waddr = b_addr;
				adj_wdata = adj_rdata | (MAX_VERTICES'(1) << a_addr);
			end
			gmc_pkg::ST_TRY: begin
				// Out of colors: uncolor v and fetch the color of v-1.
				if (v_q < n_eff && cand_over) begin
					col_we = 1'b1;
					col_raddr = AW'(v_q - NW'(1));
				end
			end
			gmc_pkg::ST_STEP: begin
				if (!conflict_q) begin
					col_we = 1'b1;
					col_wdata = c_q[CW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmc_pkg::ST_CLEAR;
			ncol_q <= gmc_pkg::CFG_W'(3);
			nvert_q <= gmc_pkg::CFG_W'(4);
			cnt_q <= '0;
			a_q <= '0;
			b_q <= '0;
			v_q <= '0;
			c_q <= '0;
			scan_q <= '0;
			pend_s1 <= 1'b0;
			pend_idx_s1 <= '0;
			conflict_q <= 1'b0;
			res_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_addr == gmc_pkg::REG_COLORS) ncol_q <= cfg_wdata;
				else nvert_q <= cfg_wdata;
			end
			unique case (state_q)
				gmc_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (s_axis_tvalid) begin
						a_q <= s_axis_tdata[5:2];
						b_q <= s_axis_tdata[9:6];
						v_q <= '0;
						c_q <= (CW+1)'(1);
					end
				end
				gmc_pkg::ST_CLEAR: cnt_q <= cnt_q + AW'(1);
				gmc_pkg::ST_TRY: begin
					scan_q <= '0;
					pend_s1 <= 1'b0;
					conflict_q <= 1'b0;
					if (v_q >= n_eff) begin
						res_q <= 1'b1;
						out_v_q <= 1'b1;
					end else if (cand_over) begin
						if (v_q == '0) begin
							res_q <= 1'b0;
							out_v_q <= 1'b1;
						end else begin
							v_q <= v_q - NW'(1);
						end
					end
				end
				gmc_pkg::ST_RESUME: c_q <= {1'b0, col_rdata} + (CW+1)'(1);
				gmc_pkg::ST_SCAN: begin
					// Issue one color read a cycle; check each return.
					pend_s1 <= scan_more;
					pend_idx_s1 <= AW'(scan_q);
					if (scan_more) scan_q <= scan_q + NW'(1);
					if (color_hit) conflict_q <= 1'b1;
				end
				gmc_pkg::ST_STEP: begin
					if (conflict_q) begin
						c_q <= c_inc;
					end else begin
						v_q <= v_q + NW'(1);
						c_q <= (CW+1)'(1);
					end
				end
				gmc_pkg::ST_DONE:
					if (m_axis_tready) out_v_q <= 1'b0;
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {7'd0, res_q};

	`GMC_ASSERT_IMP(a_ready_idle, clk, arst_n, s_axis_tready, !m_axis_tvalid)
	`GMC_ASSERT_NXT(a_clear_len, clk, arst_n, clearing && !clear_last, clearing)
	`GMC_ASSERT_IMP(a_depth, clk, arst_n, state_q == gmc_pkg::ST_SCAN, v_q < n_eff)
	`GMC_ASSERT_NXT(a_out_hold, clk, arst_n, out_v_q && !m_axis_tready, out_v_q && $stable(res_q))
endmodule
`default_nettype wire
